### sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLKRST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the clk_i / rst_ni pair of the enclosing scope.
`define ASSERT_DUT(label, prop, msg) \
  `ASSERT_CLKRST(label, clk_i, rst_ni, prop, msg)

`endif

### sv/mds_pkg.sv
package mds_pkg;

  localparam int unsigned PortWidth = 64;
  localparam int unsigned ShiftBits = 6;

  typedef enum logic [2:0] {
    CMD_UDIV = 3'd0,
    CMD_SDIV = 3'd1,
    CMD_UREM = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_SRL  = 3'd4,
    CMD_SLL  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_DIV  = 2'd1,
    MODE_MUL  = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e mode;
    logic  take_rem;
    logic  negate;
    logic  div_zero;
  } ctrl_t;

endpackage

### sv/int64_mul_div_shift_unit_top.sv
// Pipeline: one entry stage, one cell per operand bit and one output stage, all
// registered, between an accepted input beat and its output beat.
// Throughput: one beat per cycle for every operation; the whole chain holds
// while an output beat waits under stall.
// Reset: rst_ni clears all valid flags asynchronously; the chain comes up empty.
module int64_mul_div_shift_unit_top #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [63:0] operand_a_i,
  input  logic [63:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_o,
  output logic        div_by_zero_o
);
  import mds_pkg::*;

  logic                  adv;
  logic                  valid_c [DATA_WIDTH+1];
  ctrl_t                 ctrl_c  [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] x_c     [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] y_c     [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] r_c     [DATA_WIDTH+1];

  assign adv        = ~(out_valid_o & out_stall_i);
  assign in_stall_o = ~adv;

  mds_pre #(.DATA_WIDTH(DATA_WIDTH)) u_pre (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .cmd_i   (cmd_i),
    .a_i     (operand_a_i),
    .b_i     (operand_b_i),
    .valid_o (valid_c[0]),
    .ctrl_o  (ctrl_c[0]),
    .x_o     (x_c[0]),
    .y_o     (y_c[0]),
    .r_o     (r_c[0])
  );

  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
    mds_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (valid_c[k]),
      .ctrl_i  (ctrl_c[k]),
      .x_i     (x_c[k]),
      .y_i     (y_c[k]),
      .r_i     (r_c[k]),
      .valid_o (valid_c[k+1]),
      .ctrl_o  (ctrl_c[k+1]),
      .x_o     (x_c[k+1]),
      .y_o     (y_c[k+1]),
      .r_o     (r_c[k+1])
    );
  end

  mds_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (valid_c[DATA_WIDTH]),
    .ctrl_i     (ctrl_c[DATA_WIDTH]),
    .y_i        (y_c[DATA_WIDTH]),
    .r_i        (r_c[DATA_WIDTH]),
    .valid_o    (out_valid_o),
    .result_o   (result_o),
    .div_zero_o (div_by_zero_o)
  );

endmodule

### sv/mds_pre.sv
module mds_pre #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  valid_i,
  input  logic [2:0]            cmd_i,
  input  logic [63:0]           a_i,
  input  logic [63:0]           b_i,
  output logic                  valid_o,
  output mds_pkg::ctrl_t        ctrl_o,
  output logic [DATA_WIDTH-1:0] x_o,
  output logic [DATA_WIDTH-1:0] y_o,
  output logic [DATA_WIDTH-1:0] r_o
);
  import mds_pkg::*;

  localparam logic [ShiftBits:0] WidthL = (ShiftBits+1)'(DATA_WIDTH);
  localparam logic [DATA_WIDTH-1:0] One = DATA_WIDTH'(1);

  logic [DATA_WIDTH-1:0] aw, bw, mag_a, mag_b;
  logic [ShiftBits-1:0]  sh;
  logic                  big_shift, b_zero, neg_a, neg_b;

  logic                  valid_q;
  ctrl_t                 ctrl_d, ctrl_q;
  logic [DATA_WIDTH-1:0] x_d, x_q, y_d, y_q, r_d, r_q;

  assign aw        = a_i[DATA_WIDTH-1:0];
  assign bw        = b_i[DATA_WIDTH-1:0];
  assign sh        = b_i[ShiftBits-1:0];
  assign big_shift = {1'b0, sh} >= WidthL;
  assign b_zero    = (bw == '0);
  assign neg_a     = aw[DATA_WIDTH-1];
  assign neg_b     = bw[DATA_WIDTH-1];
  assign mag_a     = neg_a ? (~aw + One) : aw;
  assign mag_b     = neg_b ? (~bw + One) : bw;

  // Zero divisors and shifts are settled here and ride the chain untouched.
  always_comb begin
    ctrl_d = '{mode: MODE_PASS, take_rem: 1'b0, negate: 1'b0, div_zero: 1'b0};
    x_d    = '0;
    y_d    = '0;
    r_d    = '0;
    unique case (cmd_e'(cmd_i))
      CMD_UDIV, CMD_UREM: begin
        if (b_zero) begin
          ctrl_d.div_zero = 1'b1;
          y_d             = (cmd_e'(cmd_i) == CMD_UDIV) ? '1 : aw;
        end else begin
          ctrl_d.mode     = MODE_DIV;
          ctrl_d.take_rem = (cmd_e'(cmd_i) == CMD_UREM);
          x_d             = bw;
          y_d             = aw;
        end
      end
      CMD_SDIV: begin
        if (b_zero) begin
          ctrl_d.div_zero = 1'b1;
          y_d             = '1;
        end else begin
          ctrl_d.mode   = MODE_DIV;
          ctrl_d.negate = neg_a ^ neg_b;
          x_d           = mag_b;
          y_d           = mag_a;
        end
      end
      CMD_MUL: begin
        ctrl_d.mode = MODE_MUL;
        x_d         = aw;
        y_d         = bw;
      end
      CMD_SRL: y_d = big_shift ? '0 : (aw >> sh);
      CMD_SLL: y_d = big_shift ? '0 : (aw << sh);
      default: y_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctrl_q <= ctrl_d;
      x_q    <= x_d;
      y_q    <= y_d;
      r_q    <= r_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign r_o     = r_q;

endmodule

### sv/mds_cell.sv
module mds_cell #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  valid_i,
  input  mds_pkg::ctrl_t        ctrl_i,
  input  logic [DATA_WIDTH-1:0] x_i,
  input  logic [DATA_WIDTH-1:0] y_i,
  input  logic [DATA_WIDTH-1:0] r_i,
  output logic                  valid_o,
  output mds_pkg::ctrl_t        ctrl_o,
  output logic [DATA_WIDTH-1:0] x_o,
  output logic [DATA_WIDTH-1:0] y_o,
  output logic [DATA_WIDTH-1:0] r_o
);
  import mds_pkg::*;

  logic [DATA_WIDTH:0]   rs;
  logic [DATA_WIDTH+1:0] diff;
  logic                  fits;

  logic                  valid_q;
  ctrl_t                 ctrl_q;
  logic [DATA_WIDTH-1:0] x_d, x_q, y_d, y_q, r_d, r_q;

  // One restoring divide step: shift the next dividend bit into the partial
  // remainder and subtract the divisor when it fits.
  assign rs   = {r_i, y_i[DATA_WIDTH-1]};
  assign diff = {1'b0, rs} - {2'b00, x_i};
  assign fits = ~diff[DATA_WIDTH+1];

  always_comb begin
    x_d = x_i;
    y_d = y_i;
    r_d = r_i;
    case (ctrl_i.mode)
      MODE_DIV: begin
        r_d = fits ? diff[DATA_WIDTH-1:0] : rs[DATA_WIDTH-1:0];
        y_d = {y_i[DATA_WIDTH-2:0], fits};
      end
      MODE_MUL: begin
        // Shift-and-add: the multiplicand moves up, the multiplier down.
        r_d = r_i + (y_i[0] ? x_i : '0);
        x_d = x_i << 1;
        y_d = y_i >> 1;
      end
      default: begin
        r_d = r_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctrl_q <= ctrl_i;
      x_q    <= x_d;
      y_q    <= y_d;
      r_q    <= r_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign r_o     = r_q;

endmodule

### sv/mds_post.sv
module mds_post #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  valid_i,
  input  mds_pkg::ctrl_t        ctrl_i,
  input  logic [DATA_WIDTH-1:0] y_i,
  input  logic [DATA_WIDTH-1:0] r_i,
  output logic                  valid_o,
  output logic [63:0]           result_o,
  output logic                  div_zero_o
);
  import mds_pkg::*;

  localparam logic [DATA_WIDTH-1:0] One = DATA_WIDTH'(1);

  logic                  use_r;
  logic [DATA_WIDTH-1:0] sel;

  logic                  valid_q, div_zero_d, div_zero_q;
  logic [DATA_WIDTH-1:0] res_d, res_q;

  // Products and remainders end in r, quotients and bypassed values in y.
  assign use_r      = (ctrl_i.mode == MODE_MUL) ||
                      ((ctrl_i.mode == MODE_DIV) && ctrl_i.take_rem);
  assign sel        = use_r ? r_i : y_i;
  assign res_d      = ctrl_i.negate ? (~sel + One) : sel;
  assign div_zero_d = ctrl_i.div_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q      <= res_d;
      div_zero_q <= div_zero_d;
    end
  end

  assign valid_o    = valid_q;
  assign result_o   = PortWidth'(res_q);
  assign div_zero_o = div_zero_q;

endmodule

### sv/mds_checker.sv
`include "assert_macros.svh"

module mds_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [2:0]  cmd_i,
  input logic [63:0] operand_a_i,
  input logic [63:0] operand_b_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] result_o,
  input logic        div_by_zero_o
);

  // The input side holds exactly when a finished beat is blocked at the output.
  `ASSERT_DUT(a_stall_link, in_stall_o == (out_valid_o && out_stall_i), "input stall mismatch")

  // A new output beat can only appear on a cycle when the chain advanced.
  `ASSERT_DUT(a_rise_on_adv, $rose(out_valid_o) |-> $past(!in_stall_o), "output rose while held")

  `ASSERT_DUT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "output beat dropped")

  `ASSERT_DUT(a_out_stable,
    out_valid_o && out_stall_i |=> $stable(result_o) && $stable(div_by_zero_o),
    "stalled output changed")

endmodule

bind int64_mul_div_shift_unit_top mds_checker u_mds_checker (.*);

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mds_pkg::*;

  localparam int unsigned DW = 64;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned MAX_GAP = 9;
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;
  localparam logic [63:0] ALL_ONES = '1;
  localparam logic [63:0] SIGNED_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SIGNED_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [63:0] value;
    logic        div_zero;
  } mds_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  cmd = '0;
  logic [63:0] operand_a = '0;
  logic [63:0] operand_b = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] result;
  logic        div_by_zero;

  mds_result_t pending_results[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit          no_idle = 1'b0;

  int64_mul_div_shift_unit_top #(
    .DATA_WIDTH(DW)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (cmd),
    .operand_a_i  (operand_a),
    .operand_b_i  (operand_b),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .result_o     (result),
    .div_by_zero_o(div_by_zero)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic mds_result_t compute_mds(input logic [2:0] op, input logic [63:0] a,
                                              input logic [63:0] b);
    mds_result_t           r;
    logic [63:0]           mag_a;
    logic [63:0]           mag_b;
    logic [63:0]           quot;
    logic [ShiftBits-1:0]  sh;
    r = '0;
    sh = b[ShiftBits-1:0];
    case (op)
      CMD_UDIV: begin
        if (b == '0) begin
          r.value = ALL_ONES;
          r.div_zero = 1'b1;
        end else begin
          r.value = a / b;
        end
      end
      CMD_SDIV: begin
        if (b == '0) begin
          r.value = ALL_ONES;
          r.div_zero = 1'b1;
        end else begin
          // Magnitudes wrap so that the most negative value becomes 2^(DW-1).
          mag_a = a[DW-1] ? -a : a;
          mag_b = b[DW-1] ? -b : b;
          quot = mag_a / mag_b;
          r.value = (a[DW-1] ^ b[DW-1]) ? -quot : quot;
        end
      end
      CMD_UREM: begin
        if (b == '0) begin
          r.value = a;
          r.div_zero = 1'b1;
        end else begin
          r.value = a % b;
        end
      end
      CMD_MUL: begin
        r.value = a * b;
      end
      CMD_SRL: begin
        r.value = (sh >= DW) ? '0 : (a >> sh);
      end
      CMD_SLL: begin
        r.value = (sh >= DW) ? '0 : (a << sh);
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = 64'($urandom_range(0, 15));
      1: v = -64'($urandom_range(1, 16));
      2: v = v >> $urandom_range(1, 63);
      3: begin
        case ($urandom_range(0, 4))
          0: v = '0;
          1: v = ALL_ONES;
          2: v = SIGNED_MIN;
          3: v = SIGNED_MAX;
          default: v = 64'd1;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rand_divisor(input logic [63:0] dividend);
    logic [63:0] v;
    v = rand_operand();
    case ($urandom_range(0, 15))
      0: v = '0;
      1: v = ALL_ONES;
      2: v = dividend;
      3: v = dividend >> $urandom_range(1, 8);
      4: v = v >> $urandom_range(32, 60);
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_beat(input logic [2:0] op, input logic [63:0] a, input logic [63:0] b);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= op;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_divide_corners();
    send_beat(CMD_UDIV, ALL_ONES, 64'd3);
    send_beat(CMD_UDIV, 64'h0123_4567_89AB_CDEF, '0);
    send_beat(CMD_SDIV, SIGNED_MIN, '0);
    send_beat(CMD_UREM, 64'hDEAD_BEEF_0000_0001, '0);
    send_beat(CMD_SDIV, SIGNED_MIN, ALL_ONES);
    send_beat(CMD_SDIV, -64'd7, 64'd2);
    send_beat(CMD_SDIV, 64'd7, -64'd2);
    send_beat(CMD_SDIV, -64'd7, -64'd2);
    send_beat(CMD_SDIV, SIGNED_MIN, 64'd1);
    send_beat(CMD_UREM, ALL_ONES, 64'd10);
    send_beat(CMD_UDIV, ALL_ONES, ALL_ONES);
  endtask

  task automatic test_mul_shift_corners();
    send_beat(CMD_MUL, ALL_ONES, ALL_ONES);
    send_beat(CMD_MUL, SIGNED_MIN, 64'd2);
    send_beat(CMD_MUL, 64'h0000_0001_0000_0001, 64'h0000_0000_FFFF_FFFF);
    send_beat(CMD_SRL, ALL_ONES, 64'd63);
    send_beat(CMD_SRL, SIGNED_MIN, '0);
    send_beat(CMD_SLL, ALL_ONES, 64'd63);
    // Only the low six bits of the shift amount count.
    send_beat(CMD_SLL, 64'h8000_0000_0000_0003, 64'd67);
    send_beat(CMD_SRL, SIGNED_MAX, ALL_ONES);
  endtask

  task automatic test_unused_codes();
    send_beat(CMD_RSVD_6, ALL_ONES, ALL_ONES);
    send_beat(CMD_RSVD_7, ALL_ONES, '0);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    logic [2:0]  op;
    logic [63:0] a;
    logic [63:0] b;
    for (int unsigned i = 0; i < count; i++) begin
      op = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      a = rand_operand();
      if (op == CMD_UDIV || op == CMD_SDIV || op == CMD_UREM) begin
        b = rand_divisor(a);
      end else begin
        b = ($urandom_range(0, 1) == 0) ? rand_operand() : {$urandom, $urandom};
      end
      send_beat(op, a, b);
    end
  endtask

  task automatic test_back_to_back(input int unsigned count);
    no_idle = 1'b1;
    test_random_traffic(count);
    no_idle = 1'b0;
  endtask

  task automatic test_drain_pause();
    test_random_traffic(20);
    wait_for_drain();
    test_random_traffic(20);
  endtask

  // Receiver side: holds stall for a random number of cycles before each beat.
  initial begin : receiver
    int unsigned hold;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : scoreboard
    mds_result_t want;
    if (rst_n && in_valid && !in_stall) begin
      pending_results.push_back(compute_mds(cmd, operand_a, operand_b));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected beat: result %h, div_by_zero %0b", result, div_by_zero);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result !== want.value) begin
          $error("result: expected %h, got %h", want.value, result);
          error_count++;
        end
        if (div_by_zero !== want.div_zero) begin
          $error("div_by_zero: expected %0b, got %0b", want.div_zero, div_by_zero);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_divide_corners();
    test_mul_shift_corners();
    test_unused_codes();
    test_back_to_back(150);
    test_random_traffic(480);
    test_drain_pause();
    test_random_traffic(480);
    wait_for_drain();
    repeat (DW + 8) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/mds_pkg.sv
sv/mds_pre.sv
sv/mds_cell.sv
sv/mds_post.sv
sv/int64_mul_div_shift_unit_top.sv
sv/mds_checker.sv
verif/testbench.sv
